>>> design/cia_pkg.sv
`default_nettype none

package cia_pkg;

    // Operand and result width.
    localparam int unsigned IntWidth = 32;

    // Operation codes.
    typedef enum logic [3:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_MOD = 4'd4,
        OP_NEG = 4'd5,
        OP_AND = 4'd6,
        OP_OR  = 4'd7,
        OP_XOR = 4'd8,
        OP_NOT = 4'd9,
        OP_LE  = 4'd10,
        OP_LT  = 4'd11,
        OP_GE  = 4'd12,
        OP_GT  = 4'd13,
        OP_EQ  = 4'd14,
        OP_NE  = 4'd15
    } t_op;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    // Per-item control and early results that travel beside the divider.
    typedef struct packed {
        logic                  valid;
        t_op                   op;
        logic [IntWidth-1:0]   sval;
        t_status               sst;
        logic                  neg;
        logic                  rsign;
        t_status               dst;
    } t_ctl;

endpackage

`default_nettype wire

>>> design/cia_divider.sv
`default_nettype none

module cia_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_adv,
    input  wire logic [cia_pkg::IntWidth-1:0]  i_dividend,
    input  wire logic [cia_pkg::IntWidth-1:0]  i_divisor,
    output logic      [cia_pkg::IntWidth-1:0]  o_quot,
    output logic      [cia_pkg::IntWidth-1:0]  o_rem
);

    localparam int unsigned W = cia_pkg::IntWidth;

    logic [W-1:0] r_dvd [W];
    logic [W-1:0] r_rem [W];
    logic [W-1:0] r_dvs [W];

    // One restoring division step per stage, quotient bits shift into the dividend.
    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W-1:0] p_dvd;
        logic [W-1:0] p_rem;
        logic [W-1:0] p_dvs;
        logic [W:0]   sh;
        logic [W:0]   diff;
        logic         take;

        if (k == 0) begin : g_first
            assign p_dvd = i_dividend;
            assign p_rem = '0;
            assign p_dvs = i_divisor;
        end else begin : g_next
            assign p_dvd = r_dvd[k-1];
            assign p_rem = r_rem[k-1];
            assign p_dvs = r_dvs[k-1];
        end

        assign sh   = {p_rem, p_dvd[W-1]};
        assign diff = sh - {1'b0, p_dvs};
        assign take = (sh >= {1'b0, p_dvs});

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_dvd[k] <= {p_dvd[W-2:0], take};
                r_rem[k] <= take ? diff[W-1:0] : sh[W-1:0];
                r_dvs[k] <= p_dvs;
            end
        end
    end

    assign o_quot = r_dvd[W-1];
    assign o_rem  = r_rem[W-1];

endmodule

`default_nettype wire

>>> design/checked_integer_alu_unit.sv
// Channel | Direction | Handshake              | Payload
// input   | in        | i_valid / o_stall      | i_op, i_operand_a, i_operand_b
// result  | out       | o_valid / i_stall      | o_value, o_status
//
// One item enters per cycle while o_stall is low; each result passes the input register,
// early result stage, shared one-bit-per-stage divider stages and output register in turn.
// Reset clears every valid bit and the control chain; other payload registers are not reset.
// A stalled result freezes the whole pipeline, and o_stall is raised in that cycle.
`default_nettype none

module checked_integer_alu_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [3:0]                    i_op,
    input  wire logic [cia_pkg::IntWidth-1:0]  i_operand_a,
    input  wire logic [cia_pkg::IntWidth-1:0]  i_operand_b,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [cia_pkg::IntWidth-1:0]  o_value,
    output logic      [1:0]                    o_status
);

    localparam int unsigned W = cia_pkg::IntWidth;

    logic adv;

    // Input registers.
    logic              r_s1_valid;
    cia_pkg::t_op      r_s1_op;
    logic [W-1:0]      r_s1_a;
    logic [W-1:0]      r_s1_b;

    // Early result stage.
    cia_pkg::t_ctl     n_c2;
    cia_pkg::t_ctl     r_c2;
    logic [W-1:0]      n_ua;
    logic [W-1:0]      n_ub;
    logic [W-1:0]      r_ua;
    logic [W-1:0]      r_ub;

    // Control chain aligned with the divider stages.
    cia_pkg::t_ctl     r_ctl [W];
    cia_pkg::t_ctl     n_ctl1;
    logic [2*W-1:0]    r_prod;

    logic [W-1:0]      quot;
    logic [W-1:0]      rem;

    // Output register.
    logic              r_out_valid;
    logic [W-1:0]      r_out_value;
    cia_pkg::t_status  r_out_status;
    logic [W-1:0]      n_out_value;
    cia_pkg::t_status  n_out_status;

    // The pipeline moves unless a finished result is held by the receiver.
    assign adv     = !(r_out_valid && i_stall);
    assign o_stall = !adv;

    // Input capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_valid;
        end
        if (adv) begin
            r_s1_op <= cia_pkg::t_op'(i_op);
            r_s1_a  <= i_operand_a;
            r_s1_b  <= i_operand_b;
        end
    end

    // Add, subtract, negate, logic and compare results, plus divide checks.
    always_comb begin
        logic signed [W-1:0] sa;
        logic signed [W-1:0] sb;
        logic [W:0]          sum;
        logic [W:0]          dif;
        logic                a_min;

        sa    = $signed(r_s1_a);
        sb    = $signed(r_s1_b);
        sum   = {r_s1_a[W-1], r_s1_a} + {r_s1_b[W-1], r_s1_b};
        dif   = {r_s1_a[W-1], r_s1_a} - {r_s1_b[W-1], r_s1_b};
        a_min = r_s1_a[W-1] && (r_s1_a[W-2:0] == '0);

        n_c2       = '0;
        n_c2.valid = r_s1_valid;
        n_c2.op    = r_s1_op;
        n_c2.sst   = cia_pkg::ST_OK;
        n_c2.neg   = r_s1_a[W-1] ^ r_s1_b[W-1];
        n_c2.rsign = r_s1_a[W-1];

        if (r_s1_b == '0) begin
            n_c2.dst = cia_pkg::ST_DIV0;
        end else if (a_min && (r_s1_b == '1)) begin
            n_c2.dst = cia_pkg::ST_OVF;
        end else begin
            n_c2.dst = cia_pkg::ST_OK;
        end

        case (r_s1_op)
            cia_pkg::OP_ADD: begin
                if (sum[W] != sum[W-1]) n_c2.sst = cia_pkg::ST_OVF;
                else                    n_c2.sval = sum[W-1:0];
            end
            cia_pkg::OP_SUB: begin
                if (dif[W] != dif[W-1]) n_c2.sst = cia_pkg::ST_OVF;
                else                    n_c2.sval = dif[W-1:0];
            end
            cia_pkg::OP_NEG: begin
                if (a_min) n_c2.sst = cia_pkg::ST_OVF;
                else       n_c2.sval = W'(0) - r_s1_a;
            end
            cia_pkg::OP_AND: n_c2.sval = r_s1_a & r_s1_b;
            cia_pkg::OP_OR:  n_c2.sval = r_s1_a | r_s1_b;
            cia_pkg::OP_XOR: n_c2.sval = r_s1_a ^ r_s1_b;
            cia_pkg::OP_NOT: n_c2.sval = ~r_s1_a;
            cia_pkg::OP_LE:  n_c2.sval = W'(sa <= sb);
            cia_pkg::OP_LT:  n_c2.sval = W'(sa < sb);
            cia_pkg::OP_GE:  n_c2.sval = W'(sa >= sb);
            cia_pkg::OP_GT:  n_c2.sval = W'(sa > sb);
            cia_pkg::OP_EQ:  n_c2.sval = W'(r_s1_a == r_s1_b);
            cia_pkg::OP_NE:  n_c2.sval = W'(r_s1_a != r_s1_b);
            default:         n_c2.sval = '0;
        endcase

        n_ua = r_s1_a[W-1] ? W'(0) - r_s1_a : r_s1_a;
        n_ub = r_s1_b[W-1] ? W'(0) - r_s1_b : r_s1_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2.valid <= 1'b0;
        end else if (adv) begin
            r_c2.valid <= n_c2.valid;
        end
        if (adv) begin
            r_c2.op    <= n_c2.op;
            r_c2.sval  <= n_c2.sval;
            r_c2.sst   <= n_c2.sst;
            r_c2.neg   <= n_c2.neg;
            r_c2.rsign <= n_c2.rsign;
            r_c2.dst   <= n_c2.dst;
            r_ua       <= n_ua;
            r_ub       <= n_ub;
        end
    end

    // Magnitude product, then exact overflow check against the signed range.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod <= r_ua * r_ub;
        end
    end

    always_comb begin
        logic ovf;

        if (r_ctl[0].neg) begin
            ovf = (r_prod[2*W-1:W] != '0) || (r_prod[W-1] && (r_prod[W-2:0] != '0));
        end else begin
            ovf = (r_prod[2*W-1:W-1] != '0);
        end

        n_ctl1 = r_ctl[0];
        if (r_ctl[0].op == cia_pkg::OP_MUL) begin
            n_ctl1.sst  = ovf ? cia_pkg::ST_OVF : cia_pkg::ST_OK;
            n_ctl1.sval = r_ctl[0].neg ? W'(0) - r_prod[W-1:0] : r_prod[W-1:0];
        end
    end

    // Control chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < W; k++) begin
                r_ctl[k] <= '0;
            end
        end else if (adv) begin
            r_ctl[0] <= r_c2;
            r_ctl[1] <= n_ctl1;
            for (int k = 2; k < W; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    cia_divider u_div (
        .i_clk      (i_clk),
        .i_adv      (adv),
        .i_dividend (r_ua),
        .i_divisor  (r_ub),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    // Result selection with sign correction for divide and remainder.
    always_comb begin
        cia_pkg::t_ctl c;

        c = r_ctl[W-1];
        case (c.op)
            cia_pkg::OP_DIV: begin
                n_out_status = c.dst;
                n_out_value  = c.neg ? W'(0) - quot : quot;
            end
            cia_pkg::OP_MOD: begin
                n_out_status = c.dst;
                n_out_value  = c.rsign ? W'(0) - rem : rem;
            end
            default: begin
                n_out_status = c.sst;
                n_out_value  = c.sval;
            end
        endcase
        if (n_out_status != cia_pkg::ST_OK) begin
            n_out_value = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_ctl[W-1].valid;
        end
        if (adv) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_value  = r_out_value;
    assign o_status = r_out_status;

    // Checks.
    a_no_status3 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_status == cia_pkg::ST_OK) || (o_status == cia_pkg::ST_OVF) ||
                     (o_status == cia_pkg::ST_DIV0)))
        else $error("undefined status code");

    a_err_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != cia_pkg::ST_OK)) |-> (o_value == '0))
        else $error("nonzero value with error status");

    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

endmodule

`default_nettype wire
